// ----- sv/gtse_pkg.sv -----
// shared types, constants and elaboration-time table math for the gaussian tuning spike encoder
// no dependencies; imported by every module of the block
package gtse_pkg;

    localparam int EXP_TABLE_DEPTH_DEF = 4096;
    localparam int P_W                 = 63;   // q1.62 table word, up to 2^62
    localparam int EXP_SQ_COUNT        = 16;   // repeated squares exp(-2^k/256)

    localparam logic [P_W-1:0] Q62_ONE = P_W'(64'h4000_0000_0000_0000);

    // register indexes on the config port
    localparam logic [1:0] REG_MEAN           = 2'd0;
    localparam logic [1:0] REG_INV_SDEV       = 2'd1;
    localparam logic [1:0] REG_RATE_FRACTION  = 2'd2;
    localparam logic [1:0] REG_NOISE_FRACTION = 2'd3;

    localparam logic [15:0] INV_SDEV_RST = 16'd256;

    typedef struct packed {
        logic signed [15:0] desired_value;
        logic [15:0]        rand_rate;
        logic [15:0]        rand_noise;
    } in_item_t;

    typedef struct packed {
        logic        spike;
        logic [15:0] activation;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] mean;
        logic [15:0]        inv_sdev;
        logic [15:0]        rate_fraction;
        logic [15:0]        noise_fraction;
    } cfg_t;

    typedef enum logic [2:0] {
        FILL_BASE,
        FILL_READ,
        FILL_MUL,
        FILL_WRITE,
        FILL_DONE
    } fill_state_t;

    typedef struct packed {
        logic busy;
        logic wr_en;
        logic rd_en;
    } fill_ctrl_t;

    // exp(-1/256) in q2.62 by the alternating series, each term floored from the one before;
    // every term past the seventh floors to zero
    localparam logic [63:0] EXP_T0 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] EXP_T1 = EXP_T0 / 64'd256;
    localparam logic [63:0] EXP_T2 = EXP_T1 / 64'd512;
    localparam logic [63:0] EXP_T3 = EXP_T2 / 64'd768;
    localparam logic [63:0] EXP_T4 = EXP_T3 / 64'd1024;
    localparam logic [63:0] EXP_T5 = EXP_T4 / 64'd1280;
    localparam logic [63:0] EXP_T6 = EXP_T5 / 64'd1536;
    localparam logic [63:0] EXP_T7 = EXP_T6 / 64'd1792;
    localparam logic [63:0] EXP_BASE = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                     - EXP_T5 + EXP_T6 - EXP_T7;

    // floor(a * b / 2^62), a and b at most 2^62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // exp(-2^k/256) in q2.62
    function automatic logic [63:0] exp_sq(input int k);
        logic [63:0] c;
        c = EXP_BASE;
        for (int i = 1; i < EXP_SQ_COUNT; i++) begin
            if (i <= k) begin
                c = mul_q62(c, c);
            end
        end
        return c;
    endfunction

    localparam logic [P_W-1:0] EXP_SQ_TAB [EXP_SQ_COUNT] = '{
        P_W'(exp_sq(0)),  P_W'(exp_sq(1)),  P_W'(exp_sq(2)),  P_W'(exp_sq(3)),
        P_W'(exp_sq(4)),  P_W'(exp_sq(5)),  P_W'(exp_sq(6)),  P_W'(exp_sq(7)),
        P_W'(exp_sq(8)),  P_W'(exp_sq(9)),  P_W'(exp_sq(10)), P_W'(exp_sq(11)),
        P_W'(exp_sq(12)), P_W'(exp_sq(13)), P_W'(exp_sq(14)), P_W'(exp_sq(15))
    };

endpackage

// ----- sv/gtse_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// depends on gtse_pkg for default sizes
module gtse_ram #(
    parameter int WIDTH = gtse_pkg::P_W,
    parameter int DEPTH = gtse_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    import gtse_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/gtse_fill.sv -----
// table build sequencer: fills the exp table after reset with q1.62 products
// depends on gtse_pkg (fill states, square table, q62 one)
module gtse_fill #(
    parameter int EXP_TABLE_DEPTH = gtse_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    output gtse_pkg::fill_ctrl_t               ctrl,
    output logic [$clog2(EXP_TABLE_DEPTH)-1:0] wr_addr,
    output logic [gtse_pkg::P_W-1:0]           wr_data,
    output logic [$clog2(EXP_TABLE_DEPTH)-1:0] rd_addr,
    input  logic [gtse_pkg::P_W-1:0]           rd_data
);
    import gtse_pkg::*;

    localparam int ADDR_W = $clog2(EXP_TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(EXP_TABLE_DEPTH - 1);
    localparam logic [2:0] STEP_LAST = 3'd4;

    fill_state_t state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]        step_reg, step_next;
    logic [63:0]       pp_reg, pp_next;
    logic [1:0]        sh_reg, sh_next;
    logic [127:0]      acc_reg, acc_next;

    logic [3:0]        msb;
    logic [ADDR_W-1:0] base;
    logic              found;
    logic [P_W-1:0]    coef;
    logic [31:0]       op_a;
    logic [31:0]       op_b;

    // entry u = entry (u without its top bit) times exp(-2^top/256)
    always_comb begin
        msb   = '0;
        base  = addr_reg;
        found = 1'b0;
        for (int i = ADDR_W - 1; i >= 0; i--) begin
            if (!found && addr_reg[i]) begin
                msb     = 4'(i);
                base[i] = 1'b0;
                found   = 1'b1;
            end
        end
    end

    assign coef = EXP_SQ_TAB[msb];

    always_comb begin
        case (step_reg[1:0])
            2'd0: begin
                op_a = rd_data[31:0];
                op_b = coef[31:0];
            end
            2'd1: begin
                op_a = rd_data[31:0];
                op_b = {1'b0, coef[62:32]};
            end
            2'd2: begin
                op_a = {1'b0, rd_data[62:32]};
                op_b = coef[31:0];
            end
            default: begin
                op_a = {1'b0, rd_data[62:32]};
                op_b = {1'b0, coef[62:32]};
            end
        endcase
    end

    // next state
    always_comb begin
        case (state_reg)
            FILL_BASE:  state_next = FILL_READ;
            FILL_READ:  state_next = FILL_MUL;
            FILL_MUL:   state_next = (step_reg == STEP_LAST) ? FILL_WRITE : FILL_MUL;
            FILL_WRITE: state_next = (addr_reg == LAST_ADDR) ? FILL_DONE : FILL_READ;
            FILL_DONE:  state_next = FILL_DONE;
            default:    state_next = FILL_BASE;
        endcase
    end

    // counters and multiply-accumulate
    always_comb begin
        addr_next = addr_reg;
        step_next = step_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        case (state_reg)
            FILL_BASE: begin
                addr_next = addr_reg + ADDR_W'(1);
            end
            FILL_READ: begin
                acc_next  = '0;
                step_next = '0;
            end
            FILL_MUL: begin
                step_next = step_reg + 3'd1;
                if (step_reg != STEP_LAST) begin
                    pp_next = {32'd0, op_a} * {32'd0, op_b};
                    case (step_reg[1:0])
                        2'd0:    sh_next = 2'd0;
                        2'd3:    sh_next = 2'd2;
                        default: sh_next = 2'd1;
                    endcase
                end
                if (step_reg != 3'd0) begin
                    acc_next = acc_reg + ({64'd0, pp_reg} << {sh_reg, 5'd0});
                end
            end
            FILL_WRITE: begin
                if (addr_reg != LAST_ADDR) begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            default: begin
                addr_next = addr_reg;
            end
        endcase
    end

    // outputs
    always_comb begin
        ctrl.busy  = (state_reg != FILL_DONE);
        ctrl.wr_en = (state_reg == FILL_BASE) || (state_reg == FILL_WRITE);
        ctrl.rd_en = (state_reg == FILL_READ);
        wr_addr    = addr_reg;
        wr_data    = (state_reg == FILL_BASE) ? Q62_ONE : acc_reg[124:62];
        rd_addr    = base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FILL_BASE;
            addr_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

endmodule

// ----- sv/gtse_pipe.sv -----
// seven-stage datapath: distance, scale, saturate, square, table read, activation, spike
// depends on gtse_pkg (item and config structs); table ram sits in the top level
module gtse_pipe #(
    parameter int EXP_TABLE_DEPTH = gtse_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gtse_pkg::cfg_t                     cfg,
    input  logic                               hold,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gtse_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gtse_pkg::out_item_t                m_data,
    output logic                               rd_en,
    output logic [$clog2(EXP_TABLE_DEPTH)-1:0] rd_addr,
    input  logic [gtse_pkg::P_W-1:0]           rd_data
);
    import gtse_pkg::*;

    localparam int ADDR_W = $clog2(EXP_TABLE_DEPTH);
    localparam logic [23:0] U_MAX = 24'(EXP_TABLE_DEPTH - 1);
    localparam logic signed [33:0] Z_HI = 34'sd32767;
    localparam logic signed [33:0] Z_LO = -34'sd32768;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic en1, en2, en3, en4, en5, en6, en7;

    logic signed [16:0] d1_reg, d1_next;
    logic signed [33:0] prod2_reg, prod2_next;
    logic signed [15:0] z3_reg, z3_next;
    logic [ADDR_W-1:0]  u4_reg, u4_next;
    logic [15:0]        act6_reg, act6_next;
    logic               spike7_reg, spike7_next;
    logic [15:0]        act7_reg;

    logic [15:0] rr1_reg, rr2_reg, rr3_reg, rr4_reg, rr5_reg, rr6_reg;
    logic [15:0] rn1_reg, rn2_reg, rn3_reg, rn4_reg, rn5_reg, rn6_reg;

    logic signed [33:0] shr;
    logic signed [31:0] zz;
    logic [23:0]        sq;
    logic [31:0]        rprod;

    // a stage loads when it is empty or its content moves on
    assign en7 = !v7_reg || m_ready;
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1 && !hold;

    always_comb begin
        d1_next    = 17'(s_data.desired_value) - 17'(cfg.mean);
        prod2_next = d1_reg * $signed({1'b0, cfg.inv_sdev});

        shr = prod2_reg >>> 8;
        if (shr > Z_HI) begin
            z3_next = 16'sh7FFF;
        end else if (shr < Z_LO) begin
            z3_next = 16'sh8000;
        end else begin
            z3_next = shr[15:0];
        end

        zz = z3_reg * z3_reg;
        sq = zz[31:8];
        u4_next = (sq > U_MAX) ? ADDR_W'(EXP_TABLE_DEPTH - 1) : sq[ADDR_W-1:0];

        act6_next = rd_data[62] ? 16'hFFFF : rd_data[61:46];

        rprod       = act6_reg * cfg.rate_fraction;
        spike7_next = (rprod[31:16] > rr6_reg) || (cfg.noise_fraction > rn6_reg);
    end

    // the ram output register is stage five
    assign rd_en   = en5;
    assign rd_addr = u4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid && s_ready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_reg  <= d1_next;
            rr1_reg <= s_data.rand_rate;
            rn1_reg <= s_data.rand_noise;
        end
        if (en2) begin
            prod2_reg <= prod2_next;
            rr2_reg   <= rr1_reg;
            rn2_reg   <= rn1_reg;
        end
        if (en3) begin
            z3_reg  <= z3_next;
            rr3_reg <= rr2_reg;
            rn3_reg <= rn2_reg;
        end
        if (en4) begin
            u4_reg  <= u4_next;
            rr4_reg <= rr3_reg;
            rn4_reg <= rn3_reg;
        end
        if (en5) begin
            rr5_reg <= rr4_reg;
            rn5_reg <= rn4_reg;
        end
        if (en6) begin
            act6_reg <= act6_next;
            rr6_reg  <= rr5_reg;
            rn6_reg  <= rn5_reg;
        end
        if (en7) begin
            spike7_reg <= spike7_next;
            act7_reg   <= act6_reg;
        end
    end

    assign m_valid           = v7_reg;
    assign m_data.spike      = spike7_reg;
    assign m_data.activation = act7_reg;

endmodule

// ----- sv/gaussian_tuning_spike_encoder.sv -----
// top level of the gaussian tuning spike encoder: config registers, exp table, datapath
// depends on gtse_pkg, gtse_ram, gtse_fill and gtse_pipe
module gaussian_tuning_spike_encoder #(
    parameter int EXP_TABLE_DEPTH = gtse_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input ticks
    input  logic                s_valid,
    output logic                s_ready,
    input  gtse_pkg::in_item_t  s_data,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output gtse_pkg::out_item_t m_data,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    // one tick per request, one result request per tick; a new tick is taken every cycle
    // once the table is built and m_ready allows, each result passing through the distance,
    // scale, saturate, square, table read, activation and spike registers, stalls from the
    // result side backing up only as far as the pipeline is full. the exp(-u/256) table
    // lives in a ram of EXP_TABLE_DEPTH words that is built after reset by a sequencer with
    // one 32x32 multiplier doing four partial products per entry, and s_ready stays
    // low until it is done. config writes are taken at any time but should only be made
    // while no tick is in flight. registers at byte addresses 0 mean, 4 inv_sdev,
    // 8 rate_fraction, 12 noise_fraction; all 16 bits, mean reads back sign-extended.
    import gtse_pkg::*;

    localparam int ADDR_W = $clog2(EXP_TABLE_DEPTH);

    // config registers
    logic signed [15:0] mean_reg, mean_next;
    logic [15:0]        inv_sdev_reg, inv_sdev_next;
    logic [15:0]        rate_fraction_reg, rate_fraction_next;
    logic [15:0]        noise_fraction_reg, noise_fraction_next;
    logic               cfg_wr;
    cfg_t               cfg;

    // table build and ram port sharing
    fill_ctrl_t         fill_ctrl;
    logic [ADDR_W-1:0]  fill_wr_addr;
    logic [P_W-1:0]     fill_wr_data;
    logic [ADDR_W-1:0]  fill_rd_addr;
    logic               pipe_rd_en;
    logic [ADDR_W-1:0]  pipe_rd_addr;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [P_W-1:0]     ram_rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register write decode
    always_comb begin
        mean_next           = mean_reg;
        inv_sdev_next       = inv_sdev_reg;
        rate_fraction_next  = rate_fraction_reg;
        noise_fraction_next = noise_fraction_reg;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_MEAN:           mean_next           = pwdata[15:0];
                REG_INV_SDEV:       inv_sdev_next       = pwdata[15:0];
                REG_RATE_FRACTION:  rate_fraction_next  = pwdata[15:0];
                REG_NOISE_FRACTION: noise_fraction_next = pwdata[15:0];
                default:            mean_next           = mean_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg           <= '0;
            inv_sdev_reg       <= INV_SDEV_RST;
            rate_fraction_reg  <= '0;
            noise_fraction_reg <= '0;
        end else begin
            mean_reg           <= mean_next;
            inv_sdev_reg       <= inv_sdev_next;
            rate_fraction_reg  <= rate_fraction_next;
            noise_fraction_reg <= noise_fraction_next;
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_MEAN:           prdata = 32'(mean_reg);
            REG_INV_SDEV:       prdata = {16'd0, inv_sdev_reg};
            REG_RATE_FRACTION:  prdata = {16'd0, rate_fraction_reg};
            REG_NOISE_FRACTION: prdata = {16'd0, noise_fraction_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.mean           = mean_reg;
    assign cfg.inv_sdev       = inv_sdev_reg;
    assign cfg.rate_fraction  = rate_fraction_reg;
    assign cfg.noise_fraction = noise_fraction_reg;

    // table build sequencer, owns the ram until the table is complete
    gtse_fill #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fill_ctrl),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_addr (fill_rd_addr),
        .rd_data (ram_rd_data)
    );

    // read port goes to the sequencer while building, to the datapath after
    assign ram_rd_en   = fill_ctrl.busy ? fill_ctrl.rd_en : pipe_rd_en;
    assign ram_rd_addr = fill_ctrl.busy ? fill_rd_addr : pipe_rd_addr;

    // q1.62 exp table, activation is the top fraction bits of each word
    gtse_ram #(
        .WIDTH (P_W),
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_ram (
        .aclk    (aclk),
        .wr_en   (fill_ctrl.wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // distance, square, lookup and spike decision
    gtse_pipe #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .hold    (fill_ctrl.busy),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .rd_en   (pipe_rd_en),
        .rd_addr (pipe_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    // no tick is taken while the table is still being built
    a_no_accept_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_ctrl.busy |-> !s_ready)
        else $error("tick taken during table build");

    // no result can come out before the table exists
    a_no_result_in_build: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_ctrl.busy |-> !m_valid)
        else $error("result valid during table build");

    // the build runs once per reset
    a_build_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_ctrl.busy |=> !fill_ctrl.busy)
        else $error("table build restarted");

    // the table is only written by the build
    a_table_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_ctrl.wr_en |-> fill_ctrl.busy)
        else $error("table written after build");
`endif

endmodule
